@@ rtl/tdcr_pkg.sv @@
// Shared types, constants and font lookup for the two-field digit column renderer.
// No dependencies; every other file imports this package.
package tdcr_pkg;

  localparam int unsigned ValueW    = 14;
  localparam int unsigned ColW      = 4;
  localparam int unsigned BitsW     = 7;
  localparam int unsigned RemW      = 7;   // value modulo 100
  localparam int unsigned QuotW     = 8;   // value divided by 100, at most 163
  localparam int unsigned RecipW    = 13;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned QueueDepthDefault = 2;

  // floor(v * 5243 / 2^19) equals v / 100 for every 14-bit v
  localparam logic [RecipW-1:0] Recip      = 13'd5243;
  localparam logic [QuotW+RemW-2:0] Hundred = 14'd100;
  localparam logic [ValueW-1:0] BlankValue = 14'd9999;
  localparam logic [BitsW-1:0]  ColonBits  = 7'h28;
  localparam logic [ColW-1:0]   ColonCol   = 4'd7;
  localparam logic [ColW-1:0]   LastCol    = 4'd15;

  typedef enum logic {
    REQ_TIME  = 1'b0,
    REQ_SPLIT = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
    logic       tens_on;
    logic       units_on;
  } half_t;

  typedef struct packed {
    half_t left;
    half_t right;
    logic  colon;
  } frame_t;

  // Tens digit of a value below 100: count the decade thresholds it reaches.
  function automatic logic [3:0] tens_of(logic [RemW-1:0] m);
    logic [3:0] t;
    t = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (m >= RemW'(i * 10)) begin
        t = 4'(i);
      end
    end
    return t;
  endfunction

  // One column of the 3-wide font.
  function automatic logic [BitsW-1:0] glyph_col(logic [3:0] d, logic [1:0] i);
    logic [BitsW-1:0] c0, c1, c2;
    c0 = '0;
    c1 = '0;
    c2 = '0;
    unique case (d)
      4'd0:    begin c0 = 7'h7c; c1 = 7'h44; c2 = 7'h7c; end
      4'd1:    begin c0 = 7'h00; c1 = 7'h7c; c2 = 7'h00; end
      4'd2:    begin c0 = 7'h5c; c1 = 7'h54; c2 = 7'h74; end
      4'd3:    begin c0 = 7'h54; c1 = 7'h54; c2 = 7'h7c; end
      4'd4:    begin c0 = 7'h70; c1 = 7'h10; c2 = 7'h7c; end
      4'd5:    begin c0 = 7'h74; c1 = 7'h54; c2 = 7'h5c; end
      4'd6:    begin c0 = 7'h7c; c1 = 7'h54; c2 = 7'h5c; end
      4'd7:    begin c0 = 7'h40; c1 = 7'h40; c2 = 7'h7c; end
      4'd8:    begin c0 = 7'h7c; c1 = 7'h54; c2 = 7'h7c; end
      4'd9:    begin c0 = 7'h74; c1 = 7'h54; c2 = 7'h7c; end
      default: begin c0 = '0;    c1 = '0;    c2 = '0;    end
    endcase
    case (i)
      2'd0:    return c0;
      2'd1:    return c1;
      2'd2:    return c2;
      default: return '0;
    endcase
  endfunction

endpackage

@@ rtl/tdcr_if.sv @@
// Valid/ready channel interfaces: render requests in, column transfers out.
// Depends on tdcr_pkg for field widths.
interface tdcr_req_if;
  import tdcr_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ValueW-1:0] left_value;
  logic [ValueW-1:0] right_value;
  logic              colon_on;

  modport source (output valid, req_type, left_value, right_value, colon_on, input ready);
  modport sink   (input valid, req_type, left_value, right_value, colon_on, output ready);
endinterface

interface tdcr_col_if;
  import tdcr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ColW-1:0]  column_index;
  logic [BitsW-1:0] column_bits;
  logic             last_column;

  modport source (output valid, column_index, column_bits, last_column, input ready);
  modport sink   (input valid, column_index, column_bits, last_column, output ready);
endinterface

@@ rtl/tdcr_front.sv @@
// Front end: accept requests, reduce both values modulo 100, classify digits.
// Two-stage pipeline; depends on tdcr_pkg and tdcr_req_if.
module tdcr_front (
  input  logic              clk,
  input  logic              rst,
  tdcr_req_if.sink          req,
  output logic              fr_valid,
  input  logic              fr_ready,
  output tdcr_pkg::frame_t  fr
);
  import tdcr_pkg::*;

  // stage 1: captured request
  logic              s1_valid;
  logic              s1_split;
  logic              s1_colon;
  logic [ValueW-1:0] s1_lv, s1_rv;

  // stage 2: quotients by 100 and sentinel flags
  logic              s2_valid;
  logic              s2_split;
  logic              s2_colon;
  logic              s2_lblank, s2_rblank;
  logic [ValueW-1:0] s2_lv, s2_rv;
  logic [QuotW-1:0]  s2_lq, s2_rq;

  logic adv1, adv2;
  logic [ValueW+RecipW-1:0] lprod, rprod;
  logic [RemW-1:0] lm, rm;

  assign adv2      = s2_valid && fr_ready;
  assign adv1      = s1_valid && (!s2_valid || adv2);
  assign req.ready = !s1_valid || adv1;

  assign lprod = (ValueW+RecipW)'(s1_lv) * (ValueW+RecipW)'(Recip);
  assign rprod = (ValueW+RecipW)'(s1_rv) * (ValueW+RecipW)'(Recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (adv1) begin
        s2_valid <= 1'b1;
      end else if (adv2) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_split <= req.req_type;
      s1_colon <= req.colon_on;
      s1_lv    <= req.left_value;
      s1_rv    <= req.right_value;
    end
    if (adv1) begin
      s2_split  <= s1_split;
      s2_colon  <= s1_colon;
      s2_lblank <= (s1_lv == BlankValue);
      s2_rblank <= (s1_rv == BlankValue);
      s2_lv     <= s1_lv;
      s2_rv     <= s1_rv;
      s2_lq     <= lprod[RecipShift +: QuotW];
      s2_rq     <= rprod[RecipShift +: QuotW];
    end
  end

  // remainder fits in 7 bits since the quotient is exact
  assign lm = RemW'(s2_lv - ValueW'(ValueW'(s2_lq) * Hundred));
  assign rm = RemW'(s2_rv - ValueW'(ValueW'(s2_rq) * Hundred));

  function automatic half_t make_half(logic [RemW-1:0] m, logic blank, logic force_tens);
    half_t h;
    logic [3:0] t;
    t          = tens_of(m);
    h.tens     = t;
    h.units    = 4'(m - RemW'({t, 3'b000}) - RemW'({t, 1'b0}));
    h.units_on = !blank;
    h.tens_on  = !blank && (force_tens || (t != 4'd0));
    return h;
  endfunction

  always_comb begin
    if (req_kind_t'(s2_split) == REQ_SPLIT) begin
      fr.left  = make_half(lm, s2_lblank, 1'b0);
      fr.right = make_half(rm, s2_rblank, 1'b0);
      fr.colon = 1'b0;
    end else begin
      fr.left  = make_half(lm, 1'b0, 1'b0);
      fr.right = make_half(rm, 1'b0, 1'b1);
      fr.colon = s2_colon;
    end
  end

  assign fr_valid = s2_valid;

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !fr_ready |=> s2_valid && $stable(s2_lq) && $stable(s2_rq))
    else $error("front stage 2 lost a stalled entry");
  a_adv_fill: assert property (@(posedge clk) disable iff (rst)
    adv1 |=> s2_valid)
    else $error("front stage 2 not filled on advance");

endmodule

@@ rtl/tdcr_queue.sv @@
// Small FIFO of classified frames between front and back ends.
// Depends on tdcr_pkg for the frame type.
module tdcr_queue #(
  parameter int unsigned Depth = tdcr_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  tdcr_pkg::frame_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output tdcr_pkg::frame_t pop_data
);
  import tdcr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            push, pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count above depth");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CntW'(Depth)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/tdcr_back.sv @@
// Back end: walk the 16 columns of one frame and drive the column channel.
// Depends on tdcr_pkg and tdcr_col_if.
module tdcr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             fr_valid,
  output logic             fr_ready,
  input  tdcr_pkg::frame_t fr,
  tdcr_col_if.source       col
);
  import tdcr_pkg::*;

  frame_t           cur;
  logic             busy;
  logic [ColW-1:0]  cnt;
  logic             emit, load;
  logic [BitsW-1:0] bits;
  logic [1:0]       sub;

  assign emit     = busy && (!col.valid || col.ready);
  assign fr_ready = !busy || (emit && cnt == LastCol);
  assign load     = fr_valid && fr_ready;

  // columns 9-11 and 13-15 start one off from the low bits of the index
  assign sub = cnt[1:0] - 2'd1;

  always_comb begin
    case (cnt) inside
      4'd0, 4'd1, 4'd2:
        bits = cur.left.tens_on ? glyph_col(cur.left.tens, cnt[1:0]) : '0;
      4'd4, 4'd5, 4'd6:
        bits = cur.left.units_on ? glyph_col(cur.left.units, cnt[1:0]) : '0;
      ColonCol:
        bits = cur.colon ? ColonBits : '0;
      4'd9, 4'd10, 4'd11:
        bits = cur.right.tens_on ? glyph_col(cur.right.tens, sub) : '0;
      4'd13, 4'd14, 4'd15:
        bits = cur.right.units_on ? glyph_col(cur.right.units, sub) : '0;
      default:
        bits = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      col.valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (emit) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastCol) begin
          busy <= 1'b0;
        end
      end
      if (emit) begin
        col.valid <= 1'b1;
      end else if (col.ready) begin
        col.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= fr;
    end
    if (emit) begin
      col.column_index <= cnt;
      col.column_bits  <= bits;
      col.last_column  <= (cnt == LastCol);
    end
  end

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && cnt == '0)
    else $error("frame load did not restart the column walk");
  a_walk_on: assert property (@(posedge clk) disable iff (rst)
    emit && cnt != LastCol |=> busy && cnt == $past(cnt) + 1'b1)
    else $error("column walk stopped early");

endmodule

@@ rtl/two_field_digit_column_renderer.sv @@
// Two-field digit column renderer: renders two numbers as 16 LED matrix columns.
// Depends on tdcr_pkg, tdcr_if, tdcr_front, tdcr_queue and tdcr_back.
//
// Usage:
//   req  - valid/ready sink. One transfer carries req_type (0 time, 1 split),
//          left_value, right_value and colon_on.
//   col  - valid/ready source. Each request yields 16 transfers, column_index
//          0 up to 15, with column_bits the lit rows and last_column set on 15.
// Path: the first column of a request passes the two front stages, the queue,
//   the back end's frame register and the output register.
// Throughput: one column per cycle while col stays ready; the back end's
//   column counter sets this. The front end and the frame queue take the
//   next requests while the current frame is still being emitted, so frames
//   follow each other with no gap when col stays ready.
// Reset (rst, synchronous, active high) empties the pipeline, the queue and
//   the output register; no result is pending afterwards.
// When the receiver stalls, the output register holds its column, the back
//   end freezes, the queue fills and req.ready drops once all stages are full.
module two_field_digit_column_renderer #(
  parameter int unsigned QueueDepth = tdcr_pkg::QueueDepthDefault
) (
  input logic        clk,
  input logic        rst,
  tdcr_req_if.sink   req,
  tdcr_col_if.source col
);
  import tdcr_pkg::*;

  // front end -> queue
  logic   fq_valid, fq_ready;
  frame_t fq_data;
  // queue -> back end
  logic   qb_valid, qb_ready;
  frame_t qb_data;

  // Reduce and classify both values.
  tdcr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .fr_valid (fq_valid),
    .fr_ready (fq_ready),
    .fr       (fq_data)
  );

  // Decouple classification from column output.
  tdcr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // Walk the columns of each frame.
  tdcr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .fr_valid (qb_valid),
    .fr_ready (qb_ready),
    .fr       (qb_data),
    .col      (col)
  );

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    col.valid |-> (col.last_column == (col.column_index == LastCol)))
    else $error("last_column out of step with column_index");
  a_order: assert property (@(posedge clk) disable iff (rst)
    col.valid && col.ready && !col.last_column |=>
      !col.valid || col.column_index == $past(col.column_index) + 1'b1)
    else $error("columns out of order");

endmodule
